@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL that checks its own invariants.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("invariant violated");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("sequence violated");

`endif

@@ hw/rtl/arcc_pkg.sv @@
// ----------------------------------------------------------------------------
// arcc_pkg
// Types and constants of the access rule condition checker.
// ----------------------------------------------------------------------------
package arcc_pkg;

    // stream widths
    localparam int S_DATA_BITS = 56;
    localparam int S_USER_BITS = 2;
    localparam int M_DATA_BITS = 8;

    // request opcodes
    localparam logic [1:0] OP_RULE_WRITE = 2'd0;
    localparam logic [1:0] OP_ATTR_WRITE = 2'd1;
    localparam logic [1:0] OP_EVALUATE   = 2'd2;

    // rule word layout
    localparam int WORD_BITS = 32;
    localparam int EQUAL_BIT = 16;
    localparam int SEL_SHIFT = 8;
    localparam int SEL_BITS  = 8;

    // selectors
    localparam int ATTR_COUNT      = 19;
    localparam int ATTR_ADDR_BITS  = 5;
    localparam int FIRST_PATH_ATTR = 10;
    localparam int PATH_GROUP_ONE  = 13;
    localparam int PATH_GROUP_TWO  = 16;
    localparam logic [7:0] SEL_LITERAL = 8'd19;
    localparam logic [7:0] SEL_RANGE   = 8'd20;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    typedef enum logic [1:0] {
        K_RULE_WRITE = 2'd0,
        K_ATTR_WRITE = 2'd1,
        K_EVALUATE   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  index;
        logic [31:0] value;
        logic [6:0]  rule_length;
        logic        object_present;
        logic [2:0]  group_valid;   // path one, path one parent, path two parent
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

@@ hw/rtl/access_rule_condition_checker_unit.sv @@
// ----------------------------------------------------------------------------
// access_rule_condition_checker_unit
// Evaluates a compiled condition list against stored attribute values.
// ----------------------------------------------------------------------------
// Requests load rule words and attribute values, or evaluate the rule list
// and return one verdict on the master channel (bit 0: 1 denied). The front
// accepts one request per cycle into a two-entry command queue while it is
// not full; the back drains it. A rule or attribute write is done in the
// idle state of the back. An evaluate walks the list clause by clause: it
// reads the header and compares once per clause, fetches each attribute or
// literal operand, and fetches the minimum and then the maximum word of each
// range operand. The walk is done by the clause sequencer on the single-read
// rule memory, whose read data is registered. A result waiting on the
// master side does not stop the queue filling. Reset does not clear stores.
`include "assert_macros.svh"

module access_rule_condition_checker_unit #(
    parameter int RULE_WORDS = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index[5:0], value[37:6], rule_length[44:38], object_present[45],
    // path_one_valid[46], path_one_parent_valid[47], path_two_parent_valid[48]
    input  logic [arcc_pkg::S_DATA_BITS-1:0] s_tdata,
    // opcode[1:0]
    input  logic [arcc_pkg::S_USER_BITS-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // denied[0]
    output logic [arcc_pkg::M_DATA_BITS-1:0] m_tdata
);

    arcc_pkg::queue_stat_t q_stat;
    arcc_pkg::cmd_t        push_cmd;
    arcc_pkg::cmd_t        head_cmd;
    logic                  push;
    logic                  pop;
    logic                  denied;
    logic                  write_popped;

    arcc_front #(
        .RULE_WORDS(RULE_WORDS)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_stat  (q_stat),
        .push    (push),
        .cmd     (push_cmd)
    );

    arcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .stat    (q_stat)
    );

    arcc_back #(
        .RULE_WORDS(RULE_WORDS),
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (head_cmd),
        .cmd_valid (!q_stat.empty),
        .cmd_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_denied(denied)
    );

    assign m_tdata = {(arcc_pkg::M_DATA_BITS - 1)'(0), denied};

    assign write_popped = pop && !m_tvalid && (head_cmd.kind != arcc_pkg::K_EVALUATE);

    `ASSERT_ALWAYS(a_no_push_when_full, aclk, aresetn, !(push && q_stat.full))
    `ASSERT_ALWAYS(a_no_pop_when_empty, aclk, aresetn, !(pop && q_stat.empty))
    `ASSERT_NEXT(a_write_gives_no_result, aclk, aresetn, write_popped, !m_tvalid)

endmodule

@@ hw/rtl/arcc_front.sv @@
// ----------------------------------------------------------------------------
// arcc_front
// Accepts requests, classifies them and drops those that have no effect.
// ----------------------------------------------------------------------------
module arcc_front #(
    parameter int RULE_WORDS = 64
) (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index[5:0], value[37:6], rule_length[44:38], object_present[45],
    // path_one_valid[46], path_one_parent_valid[47], path_two_parent_valid[48]
    input  logic [arcc_pkg::S_DATA_BITS-1:0] s_tdata,
    // opcode[1:0]
    input  logic [arcc_pkg::S_USER_BITS-1:0] s_tuser,
    input  arcc_pkg::queue_stat_t            q_stat,
    output logic                             push,
    output arcc_pkg::cmd_t                   cmd
);

    logic [31:0] index_wide;
    logic        keep;

    assign s_tready   = !q_stat.full;
    assign index_wide = 32'(s_tdata[5:0]);

    always_comb begin
        cmd.index          = s_tdata[5:0];
        cmd.value          = s_tdata[37:6];
        cmd.rule_length    = s_tdata[44:38];
        cmd.object_present = s_tdata[45];
        cmd.group_valid    = s_tdata[48:46];
        cmd.kind           = arcc_pkg::K_EVALUATE;
        keep               = 1'b0;
        case (s_tuser)
            arcc_pkg::OP_RULE_WRITE: begin
                cmd.kind = arcc_pkg::K_RULE_WRITE;
                keep     = index_wide < 32'(RULE_WORDS);
            end
            arcc_pkg::OP_ATTR_WRITE: begin
                cmd.kind = arcc_pkg::K_ATTR_WRITE;
                keep     = index_wide < 32'(arcc_pkg::ATTR_COUNT);
            end
            arcc_pkg::OP_EVALUATE: begin
                cmd.kind = arcc_pkg::K_EVALUATE;
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    // drop out-of-range writes and the unused opcode
    assign push = s_tvalid && s_tready && keep;

endmodule

@@ hw/rtl/arcc_queue.sv @@
// ----------------------------------------------------------------------------
// arcc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module arcc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  arcc_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output arcc_pkg::cmd_t        head_cmd,
    output arcc_pkg::queue_stat_t stat
);

    arcc_pkg::cmd_t                   entry_reg [arcc_pkg::QUEUE_DEPTH];
    logic [arcc_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [arcc_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [arcc_pkg::QCNT_BITS-1:0]   count_reg, count_next;

    assign stat.full  = count_reg == arcc_pkg::QCNT_BITS'(arcc_pkg::QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (push ? arcc_pkg::QPTR_BITS'(1) : '0);
        rd_ptr_next = rd_ptr_reg + (pop ? arcc_pkg::QPTR_BITS'(1) : '0);
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + arcc_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - arcc_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/arcc_back.sv @@
// ----------------------------------------------------------------------------
// arcc_back
// Carries out commands: store writes and the clause walk of an evaluate.
// ----------------------------------------------------------------------------
module arcc_back #(
    parameter int RULE_WORDS = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  arcc_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_denied
);

    localparam int RA_W  = $clog2(RULE_WORDS);
    localparam int LEN_W = $clog2(RULE_WORDS + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_HEAD = 9'b000000010,
        S_OPER = 9'b000000100,
        S_ATTR = 9'b000001000,
        S_LIT  = 9'b000010000,
        S_RLO  = 9'b000100000,
        S_RHI  = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    // stores
    logic [arcc_pkg::WORD_BITS-1:0]      rule_mem [RULE_WORDS];
    logic [VALUE_BITS-1:0]               attr_mem [arcc_pkg::ATTR_COUNT];
    logic [arcc_pkg::WORD_BITS-1:0]      rule_rdata_reg;
    logic [VALUE_BITS-1:0]               attr_rdata_reg;
    logic                                rule_we, attr_we;
    logic [RA_W-1:0]                     rule_waddr, rule_raddr;
    logic [arcc_pkg::ATTR_ADDR_BITS-1:0] attr_waddr, attr_raddr;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       pos_reg, pos_next;
    logic                   obj_reg, obj_next;
    logic [2:0]             grp_reg, grp_next;
    logic                   eq_reg, eq_next;
    logic [7:0]             left_reg, left_next;
    logic [7:0]             right_reg, right_next;
    logic                   side_reg, side_next;
    logic [VALUE_BITS-1:0]  l_lo_reg, l_lo_next, l_hi_reg, l_hi_next;
    logic [VALUE_BITS-1:0]  r_lo_reg, r_lo_next, r_hi_reg, r_hi_next;
    logic                   verdict_reg, verdict_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_denied_reg, out_denied_next;

    logic [31:0]            len_wide, index_wide;
    logic [7:0]             sel;
    logic                   grp_ok;
    logic [LEN_W:0]         pos_p1;
    logic [LEN_W-1:0]       pos_m1;
    logic [VALUE_BITS-1:0]  rule_val;
    logic                   overlap;
    logic                   left_path, right_path;

    assign out_valid  = out_valid_reg;
    assign out_denied = out_denied_reg;

    assign len_wide   = 32'(cmd.rule_length);
    assign index_wide = 32'(cmd.index);
    assign rule_waddr = index_wide[RA_W-1:0];
    assign attr_waddr = cmd.index[arcc_pkg::ATTR_ADDR_BITS-1:0];
    assign sel        = side_reg ? right_reg : left_reg;
    assign pos_p1     = {1'b0, pos_reg} + (LEN_W + 1)'(1);
    assign pos_m1     = pos_reg - LEN_W'(1);
    assign rule_val   = VALUE_BITS'(rule_rdata_reg);
    assign overlap    = (l_lo_reg <= r_hi_reg) && (l_hi_reg >= r_lo_reg);

    always_comb begin
        if (sel < 8'(arcc_pkg::PATH_GROUP_ONE)) begin
            grp_ok = grp_reg[0];
        end else if (sel < 8'(arcc_pkg::PATH_GROUP_TWO)) begin
            grp_ok = grp_reg[1];
        end else begin
            grp_ok = grp_reg[2];
        end
    end

    always_comb begin
        left_path  = (rule_rdata_reg[15:8] >= 8'(arcc_pkg::FIRST_PATH_ATTR))
                  && (rule_rdata_reg[15:8] < 8'(arcc_pkg::ATTR_COUNT));
        right_path = (rule_rdata_reg[7:0] >= 8'(arcc_pkg::FIRST_PATH_ATTR))
                  && (rule_rdata_reg[7:0] < 8'(arcc_pkg::ATTR_COUNT));
    end

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        obj_next        = obj_reg;
        grp_next        = grp_reg;
        eq_next         = eq_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        side_next       = side_reg;
        l_lo_next       = l_lo_reg;
        l_hi_next       = l_hi_reg;
        r_lo_next       = r_lo_reg;
        r_hi_next       = r_hi_reg;
        verdict_next    = verdict_reg;
        out_denied_next = out_denied_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd_pop         = 1'b0;
        rule_we         = 1'b0;
        attr_we         = 1'b0;
        rule_raddr      = pos_reg[RA_W-1:0];
        attr_raddr      = sel[arcc_pkg::ATTR_ADDR_BITS-1:0];

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        arcc_pkg::K_RULE_WRITE: rule_we = 1'b1;
                        arcc_pkg::K_ATTR_WRITE: attr_we = 1'b1;
                        arcc_pkg::K_EVALUATE: begin
                            obj_next     = cmd.object_present;
                            grp_next     = cmd.group_valid;
                            verdict_next = 1'b0;
                            // saturate the list length to the store depth
                            if (len_wide > 32'(RULE_WORDS)) begin
                                len_next = LEN_W'(RULE_WORDS);
                            end else begin
                                len_next = len_wide[LEN_W-1:0];
                            end
                            if (len_wide == '0) begin
                                state_next = S_DONE;
                            end else begin
                                rule_raddr = '0;
                                pos_next   = LEN_W'(1);
                                state_next = S_HEAD;
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            S_HEAD: begin
                eq_next    = rule_rdata_reg[arcc_pkg::EQUAL_BIT];
                left_next  = rule_rdata_reg[arcc_pkg::SEL_SHIFT +: arcc_pkg::SEL_BITS];
                right_next = rule_rdata_reg[arcc_pkg::SEL_BITS-1:0];
                side_next  = 1'b0;
                if ((left_path || right_path) && !obj_reg) begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    state_next = S_OPER;
                end
            end
            S_OPER: begin
                if (sel < 8'(arcc_pkg::ATTR_COUNT)) begin
                    if (sel >= 8'(arcc_pkg::FIRST_PATH_ATTR) && !grp_ok) begin
                        verdict_next = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_ATTR;
                    end
                end else if (sel == arcc_pkg::SEL_LITERAL) begin
                    if (pos_reg >= len_reg) begin
                        verdict_next = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        pos_next   = pos_p1[LEN_W-1:0];
                        state_next = S_LIT;
                    end
                end else if (sel == arcc_pkg::SEL_RANGE) begin
                    if (pos_p1 >= {1'b0, len_reg}) begin
                        verdict_next = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        pos_next   = pos_reg + LEN_W'(2);
                        state_next = S_RLO;
                    end
                end else begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_ATTR, S_LIT, S_RHI: begin
                if (side_reg) begin
                    if (state_reg != S_RHI) begin
                        r_lo_next = (state_reg == S_ATTR) ? attr_rdata_reg : rule_val;
                    end
                    r_hi_next  = (state_reg == S_ATTR) ? attr_rdata_reg : rule_val;
                    state_next = S_CMP;
                end else begin
                    if (state_reg != S_RHI) begin
                        l_lo_next = (state_reg == S_ATTR) ? attr_rdata_reg : rule_val;
                    end
                    l_hi_next  = (state_reg == S_ATTR) ? attr_rdata_reg : rule_val;
                    side_next  = 1'b1;
                    state_next = S_OPER;
                end
            end
            S_RLO: begin
                // take the minimum and fetch the maximum word
                if (side_reg) begin
                    r_lo_next = rule_val;
                end else begin
                    l_lo_next = rule_val;
                end
                rule_raddr = pos_m1[RA_W-1:0];
                state_next = S_RHI;
            end
            S_CMP: begin
                if (eq_reg != overlap) begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end else if (pos_reg >= len_reg) begin
                    state_next = S_DONE;
                end else begin
                    pos_next   = pos_p1[LEN_W-1:0];
                    state_next = S_HEAD;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_denied_next = verdict_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        obj_reg        <= obj_next;
        grp_reg        <= grp_next;
        eq_reg         <= eq_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        side_reg       <= side_next;
        l_lo_reg       <= l_lo_next;
        l_hi_reg       <= l_hi_next;
        r_lo_reg       <= r_lo_next;
        r_hi_reg       <= r_hi_next;
        verdict_reg    <= verdict_next;
        out_denied_reg <= out_denied_next;
    end

    always_ff @(posedge aclk) begin
        if (rule_we) begin
            rule_mem[rule_waddr] <= cmd.value;
        end
        rule_rdata_reg <= rule_mem[rule_raddr];
    end

    always_ff @(posedge aclk) begin
        if (attr_we) begin
            attr_mem[attr_waddr] <= VALUE_BITS'(cmd.value);
        end
        attr_rdata_reg <= attr_mem[attr_raddr];
    end

endmodule

@@ tb/sv/arcc_verdict_check.sv @@
// ----------------------------------------------------------------------------
// arcc_verdict_check
// Tracks rule and attribute writes on the request stream and checks each
// verdict returned on the result stream.
// ----------------------------------------------------------------------------
// Every accepted request is applied to local copies of the rule and attribute
// stores in acceptance order. An evaluate request walks the local rule list
// at once and queues the expected verdict. Each verdict taken from the result
// stream is compared with the oldest queued one.
module arcc_verdict_check
    import arcc_pkg::*;
#(
    parameter int RULE_WORDS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    // index[5:0], value[37:6], rule_length[44:38], object_present[45],
    // path_one_valid[46], path_one_parent_valid[47], path_two_parent_valid[48]
    input  logic [S_DATA_BITS-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [S_USER_BITS-1:0]  s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    // denied[0]
    input  logic [M_DATA_BITS-1:0]  m_tdata,
    output int                      fail_count,
    output int                      pending_verdicts,
    output int                      verdict_count,
    output int                      denied_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_BITS-1:0] rule_copy [RULE_WORDS];
    logic [WORD_BITS-1:0] attr_copy [ATTR_COUNT];
    bit                   expected_verdicts [$];

    // Resolve one operand into a range; 0 means the clause denies.
    function automatic bit operand_range(input logic [7:0] sel, inout int unsigned pos,
                                         input int unsigned len, input logic [2:0] grp,
                                         output logic [WORD_BITS-1:0] lo,
                                         output logic [WORD_BITS-1:0] hi);
        lo = '0;
        hi = '0;
        if (sel < ATTR_COUNT) begin
            if (sel >= FIRST_PATH_ATTR && !grp[(sel - FIRST_PATH_ATTR) / 3])
                return 1'b0;
            lo = attr_copy[sel];
            hi = lo;
            return 1'b1;
        end
        if (sel == SEL_LITERAL) begin
            if (pos >= len)
                return 1'b0;
            lo = rule_copy[pos];
            hi = lo;
            pos++;
            return 1'b1;
        end
        if (sel == SEL_RANGE) begin
            if (pos + 1 >= len)
                return 1'b0;
            lo = rule_copy[pos];
            hi = rule_copy[pos + 1];
            pos += 2;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit rule_list_denies(input int unsigned length, input logic obj,
                                            input logic [2:0] grp);
        int unsigned          pos;
        int unsigned          len;
        logic [WORD_BITS-1:0] hdr;
        logic [7:0]           left_sel;
        logic [7:0]           right_sel;
        logic [WORD_BITS-1:0] lmin, lmax, rmin, rmax;
        bit                   is_equal;
        pos = 0;
        len = (length > RULE_WORDS) ? RULE_WORDS : length;
        while (pos < len) begin
            hdr = rule_copy[pos];
            is_equal = hdr[EQUAL_BIT];
            left_sel = hdr[SEL_SHIFT +: SEL_BITS];
            right_sel = hdr[SEL_BITS-1:0];
            pos++;
            if (!obj && ((left_sel >= FIRST_PATH_ATTR && left_sel < ATTR_COUNT) ||
                         (right_sel >= FIRST_PATH_ATTR && right_sel < ATTR_COUNT)))
                return 1'b1;
            if (!operand_range(left_sel, pos, len, grp, lmin, lmax))
                return 1'b1;
            if (!operand_range(right_sel, pos, len, grp, rmin, rmax))
                return 1'b1;
            if (is_equal) begin
                if (!(lmin <= rmax && lmax >= rmin))
                    return 1'b1;
            end else begin
                if (!(lmin > rmax || lmax < rmin))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    initial begin
        fail_count = 0;
        pending_verdicts = 0;
        verdict_count = 0;
        denied_count = 0;
    end

    always @(posedge aclk) begin
        logic [1:0]           op;
        logic [5:0]           idx;
        logic [WORD_BITS-1:0] val;
        bit                   want;
        if (!aresetn) begin
            expected_verdicts.delete();
            pending_verdicts = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("denied: verdict %0d arrived with no evaluate pending", m_tdata[0]);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    verdict_count++;
                    if (m_tdata[0] !== want) begin
                        $error("denied mismatch: expected %0d, actual %0d", want, m_tdata[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                op = s_tuser;
                idx = s_tdata[5:0];
                val = s_tdata[37:6];
                case (op)
                    OP_RULE_WRITE: begin
                        if (idx < RULE_WORDS)
                            rule_copy[idx] = val;
                    end
                    OP_ATTR_WRITE: begin
                        if (idx < ATTR_COUNT)
                            attr_copy[idx] = val;
                    end
                    OP_EVALUATE: begin
                        want = rule_list_denies(s_tdata[44:38], s_tdata[45], s_tdata[48:46]);
                        expected_verdicts.push_back(want);
                        if (want)
                            denied_count++;
                    end
                    default: ;
                endcase
            end
            pending_verdicts = expected_verdicts.size();
        end
    end

endmodule

@@ tb/sv/access_rule_condition_checker_unit_test.sv @@
// ----------------------------------------------------------------------------
// access_rule_condition_checker_unit_test
// Stream-level test of the access rule condition checker.
// ----------------------------------------------------------------------------
// Fills both stores, runs a short directed list of corner clauses, then loads
// random clause lists and evaluates them under four idle and stall mixes,
// including a long result hold-off that backs the request queue up. Verdicts
// are checked by arcc_verdict_check.
module access_rule_condition_checker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import arcc_pkg::*;

    localparam int         RULE_WORDS  = 64;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         LONG_HOLD   = 300;
    localparam int         DRAIN_WAIT  = 400;
    localparam int         PHASE_ITEMS = 70;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic [S_USER_BITS-1:0] s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;

    int fail_count;
    int pending_verdicts;
    int verdict_count;
    int denied_count;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;

    logic [WORD_BITS-1:0] attr_shadow [ATTR_COUNT];
    logic [WORD_BITS-1:0] program_words [$];

    access_rule_condition_checker_unit #(
        .RULE_WORDS(RULE_WORDS),
        .VALUE_BITS(WORD_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    arcc_verdict_check #(
        .RULE_WORDS(RULE_WORDS)
    ) verdict_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .fail_count(fail_count),
        .pending_verdicts(pending_verdicts),
        .verdict_count(verdict_count),
        .denied_count(denied_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d verdicts pending",
                     cycle_count, pending_verdicts);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when requested.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [1:0] op, input logic [5:0] idx,
                                input logic [WORD_BITS-1:0] val, input logic [6:0] len,
                                input logic obj, input logic [2:0] grp);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'b0, grp, obj, len, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (!(op == OP_UNUSED || (op == OP_ATTR_WRITE && idx >= ATTR_COUNT)))
            requests_sent++;
        @(negedge aclk);
    endtask

    task automatic write_rule(input int idx, input logic [WORD_BITS-1:0] val);
        send_request(OP_RULE_WRITE, 6'(idx), val, 7'($urandom), 1'($urandom), 3'($urandom));
    endtask

    task automatic write_attr(input int idx, input logic [WORD_BITS-1:0] val);
        if (idx < ATTR_COUNT)
            attr_shadow[idx] = val;
        send_request(OP_ATTR_WRITE, 6'(idx), val, 7'($urandom), 1'($urandom), 3'($urandom));
    endtask

    task automatic evaluate(input int len, input logic obj, input logic [2:0] grp);
        send_request(OP_EVALUATE, 6'($urandom), $urandom, 7'(len), obj, grp);
    endtask

    task automatic send_unused();
        send_request(OP_UNUSED, 6'($urandom), $urandom, 7'($urandom), 1'($urandom),
                     3'($urandom));
    endtask

    task automatic evaluate_random_flags(input int len);
        evaluate(len, $urandom_range(7) != 0,
                 {$urandom_range(7) != 0, $urandom_range(7) != 0, $urandom_range(7) != 0});
    endtask

    task automatic load_program();
        foreach (program_words[i])
            write_rule(i, program_words[i]);
    endtask

    // Drop valid and hold off until every expected verdict is back.
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        wait (pending_verdicts == 0);
        @(negedge aclk);
    endtask

    function automatic logic [WORD_BITS-1:0] random_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_BITS-1:0] clause_header(input bit is_equal,
                                                           input logic [7:0] left_sel,
                                                           input logic [7:0] right_sel);
        logic [WORD_BITS-1:0] hdr;
        hdr = $urandom;
        hdr[EQUAL_BIT] = is_equal;
        hdr[SEL_SHIFT +: SEL_BITS] = left_sel;
        hdr[SEL_BITS-1:0] = right_sel;
        return hdr;
    endfunction

    function automatic logic [7:0] pick_selector();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 8'($urandom_range(FIRST_PATH_ATTR - 1));
        if (r < 45)
            return 8'($urandom_range(ATTR_COUNT - 1, FIRST_PATH_ATTR));
        if (r < 70)
            return SEL_LITERAL;
        if (r < 94)
            return SEL_RANGE;
        return 8'($urandom_range(255, SEL_RANGE + 1));
    endfunction

    // Literals and ranges mostly sit near the attribute they are compared with.
    function automatic void append_body(input logic [7:0] sel, input logic [WORD_BITS-1:0] target);
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] hi;
        if (sel == SEL_LITERAL) begin
            program_words.push_back($urandom_range(1) ? target : random_value());
        end else if (sel == SEL_RANGE) begin
            lo = target - $urandom_range(3);
            hi = target + $urandom_range(3);
            case ($urandom_range(3))
                0: begin
                    lo = random_value();
                    hi = random_value();
                end
                1: {lo, hi} = {hi, lo};
                default: ;
            endcase
            program_words.push_back(lo);
            program_words.push_back(hi);
        end
    endfunction

    function automatic void append_clause();
        logic [7:0]           left_sel;
        logic [7:0]           right_sel;
        logic [WORD_BITS-1:0] target;
        left_sel = pick_selector();
        right_sel = pick_selector();
        if (left_sel < ATTR_COUNT)
            target = attr_shadow[left_sel];
        else if (right_sel < ATTR_COUNT)
            target = attr_shadow[right_sel];
        else
            target = random_value();
        program_words.push_back(clause_header($urandom_range(99) < 60, left_sel, right_sel));
        append_body(left_sel, target);
        append_body(right_sel, target);
    endfunction

    task automatic random_program_run();
        int clauses;
        int target_clauses;
        target_clauses = ($urandom_range(14) == 0) ? 20 : $urandom_range(1, 4);
        clauses = 0;
        program_words.delete();
        while (clauses < target_clauses && program_words.size() <= RULE_WORDS - 5) begin
            append_clause();
            clauses++;
        end
        load_program();
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(4) != 0)
                evaluate_random_flags(program_words.size());
            else
                evaluate_random_flags($urandom_range(127));
        end
    endtask

    task automatic run_phase(input int idle, input int stall);
        int first;
        int pick;
        idle_pct = idle;
        stall_pct = stall;
        first = requests_sent;
        while (requests_sent - first < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60)
                random_program_run();
            else if (pick < 72)
                write_attr($urandom_range(31), random_value());
            else if (pick < 80)
                write_rule($urandom_range(RULE_WORDS - 1), $urandom);
            else if (pick < 85)
                send_unused();
            else
                evaluate_random_flags($urandom_range(127));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill both stores so no evaluate can read an unwritten entry;
        // every rule word starts as a clause that compares attribute 0 with itself.
        for (int i = 0; i < ATTR_COUNT; i++)
            write_attr(i, random_value());
        for (int i = 0; i < RULE_WORDS; i++)
            write_rule(i, clause_header(1'b1, 8'd0, 8'd0));

        // Directed corners.
        evaluate(0, 1'b0, 3'b000);
        write_attr(0, '0);
        write_attr(1, '1);
        write_attr(ATTR_COUNT + 12, $urandom);
        send_unused();

        // full-scale range, then the same list with its range cut short
        program_words = '{clause_header(1'b1, 8'd1, SEL_RANGE), '0, '1};
        load_program();
        evaluate(3, 1'b1, 3'b111);
        evaluate(2, 1'b1, 3'b111);

        // not-equal on matching values, and a missing literal
        program_words = '{clause_header(1'b0, 8'd0, SEL_LITERAL), '0};
        load_program();
        evaluate(2, 1'b1, 3'b111);
        evaluate(1, 1'b1, 3'b111);

        // path attributes: no object, invalid group, valid group
        write_rule(0, clause_header(1'b1, 8'd12, 8'd12));
        evaluate(1, 1'b0, 3'b111);
        evaluate(1, 1'b1, 3'b110);
        evaluate(1, 1'b1, 3'b001);
        write_rule(0, clause_header(1'b1, 8'd15, 8'd18));
        evaluate(1, 1'b1, 3'b101);
        evaluate(1, 1'b1, 3'b011);

        // unknown selector
        write_rule(0, clause_header(1'b1, 8'hFF, 8'd0));
        evaluate(1, 1'b1, 3'b111);

        // range given with min above max
        program_words = '{clause_header(1'b1, SEL_LITERAL, SEL_RANGE), 32'd7, 32'd10, 32'd5};
        load_program();
        evaluate(4, 1'b1, 3'b111);

        // full-depth walk and a length beyond the store
        write_rule(0, clause_header(1'b1, 8'd0, 8'd0));
        evaluate(RULE_WORDS, 1'b1, 3'b111);
        evaluate(127, 1'b0, 3'b000);
        drain_verdicts();

        // Back the queue up behind a held result channel.
        hold_request = 1'b1;
        run_phase(0, 0);
        drain_verdicts();
        run_phase(49, 0);
        drain_verdicts();
        run_phase(0, 49);
        drain_verdicts();
        run_phase(31, 31);

        s_tvalid <= 1'b0;
        wait (pending_verdicts == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d requests; %0d verdicts compared, %0d of them denied.",
                 requests_sent, verdict_count, denied_count);
        $display({"Covered empty, truncated, full-depth and saturated lists ",
                  "under idle, stall and hold-off."});
        if (fail_count == 0 && pending_verdicts == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
